### hw/rtl/rmsdb_pkg.sv
// Shared types, constants and the control store of the RMS sound level core.
// Holds the micro-operation and jump-condition codes and the microprogram.
// No dependencies.
package rmsdb_pkg;

  // Frame length limit and the widths that follow from it.
  localparam int unsigned MAX_SAMPLES = 512;
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W       = $clog2(MAX_SAMPLES) + 31;
  localparam int unsigned EXP_W       = $clog2(SUM_W);

  // Logarithm format: integer part EXP_W bits, fraction FRAC_W bits.
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned RND_W   = $clog2(FRAC_W);
  localparam int unsigned MANT_W  = 31;
  localparam int unsigned LOG_W   = EXP_W + FRAC_W;
  localparam int unsigned DIFF_W  = LOG_W + 2;

  // Shared multiplier.
  localparam int unsigned MUL_W   = 32;
  localparam int unsigned PROD_W  = 2 * MUL_W;

  // 2560*log10(2) in Q16; the product with the Q24 difference is Q40.
  localparam logic [25:0] DB_SCALE    = 26'd50504453;
  localparam int unsigned ROUND_SHIFT = 40;
  localparam int unsigned MAG_W       = PROD_W - ROUND_SHIFT;

  // 2*log2(1024) = 20 in log2 units, placed in Q24.
  localparam logic [DIFF_W-1:0] DIFF_OFFSET = DIFF_W'(20) << FRAC_W;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 16;

  localparam int unsigned PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    U_IDLE,
    U_SQUARE,
    U_ACC,
    U_LOAD_SUM,
    U_NORM,
    U_LOG_INIT,
    U_MUL_M,
    U_LOG_STEP,
    U_SAVE_LOAD_CNT,
    U_DIFF,
    U_ABS,
    U_MUL_D,
    U_EMIT,
    U_FLOOR
  } uop_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT_IN,
    C_NOT_LAST,
    C_SUM_ZERO,
    C_NORM,
    C_ROUNDS,
    C_OUT_FREE,
    C_JUMP
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Step addresses of the microprogram.
  localparam pc_t S_WAIT     = 5'd0;
  localparam pc_t S_SQUARE   = 5'd1;
  localparam pc_t S_ACC      = 5'd2;
  localparam pc_t S_LOAD_SUM = 5'd3;
  localparam pc_t S_NORM_S   = 5'd4;
  localparam pc_t S_INIT_S   = 5'd5;
  localparam pc_t S_MUL_S    = 5'd6;
  localparam pc_t S_STEP_S   = 5'd7;
  localparam pc_t S_SAVE     = 5'd8;
  localparam pc_t S_NORM_C   = 5'd9;
  localparam pc_t S_INIT_C   = 5'd10;
  localparam pc_t S_MUL_C    = 5'd11;
  localparam pc_t S_STEP_C   = 5'd12;
  localparam pc_t S_DIFF     = 5'd13;
  localparam pc_t S_ABS      = 5'd14;
  localparam pc_t S_MUL_D    = 5'd15;
  localparam pc_t S_EMIT     = 5'd16;
  localparam pc_t S_FLOOR    = 5'd17;

  // Control store. A true condition takes the target, otherwise the step
  // advances; the wait conditions hold the current step instead.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: U_IDLE, cond: C_JUMP, target: S_WAIT};
    unique case (pc)
      S_WAIT:     w = '{op: U_IDLE,          cond: C_WAIT_IN,  target: S_WAIT};
      S_SQUARE:   w = '{op: U_SQUARE,        cond: C_NEXT,     target: S_WAIT};
      S_ACC:      w = '{op: U_ACC,           cond: C_NOT_LAST, target: S_WAIT};
      S_LOAD_SUM: w = '{op: U_LOAD_SUM,      cond: C_SUM_ZERO, target: S_FLOOR};
      S_NORM_S:   w = '{op: U_NORM,          cond: C_NORM,     target: S_NORM_S};
      S_INIT_S:   w = '{op: U_LOG_INIT,      cond: C_NEXT,     target: S_WAIT};
      S_MUL_S:    w = '{op: U_MUL_M,         cond: C_NEXT,     target: S_WAIT};
      S_STEP_S:   w = '{op: U_LOG_STEP,      cond: C_ROUNDS,   target: S_MUL_S};
      S_SAVE:     w = '{op: U_SAVE_LOAD_CNT, cond: C_NEXT,     target: S_WAIT};
      S_NORM_C:   w = '{op: U_NORM,          cond: C_NORM,     target: S_NORM_C};
      S_INIT_C:   w = '{op: U_LOG_INIT,      cond: C_NEXT,     target: S_WAIT};
      S_MUL_C:    w = '{op: U_MUL_M,         cond: C_NEXT,     target: S_WAIT};
      S_STEP_C:   w = '{op: U_LOG_STEP,      cond: C_ROUNDS,   target: S_MUL_C};
      S_DIFF:     w = '{op: U_DIFF,          cond: C_NEXT,     target: S_WAIT};
      S_ABS:      w = '{op: U_ABS,           cond: C_NEXT,     target: S_WAIT};
      S_MUL_D:    w = '{op: U_MUL_D,         cond: C_NEXT,     target: S_WAIT};
      S_EMIT:     w = '{op: U_EMIT,          cond: C_OUT_FREE, target: S_WAIT};
      S_FLOOR:    w = '{op: U_FLOOR,         cond: C_OUT_FREE, target: S_WAIT};
      default:    w = '{op: U_IDLE,          cond: C_JUMP,     target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/rms_sound_level_db_core.sv
// RMS sound level core: microcoded sequencer, shared multiplier and log datapath.
// Depends on rmsdb_pkg for widths, codes and the control store.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | in_sample (s16), in_last
//  out      | out_valid / out_stall| out_level_db (s16, 1/256 dB)
//
// A sample beat that does not end a frame runs the wait, square and add steps.
// A frame-end beat then runs the level routine: two normalizing shift loops
// (one bit per cycle), two logarithms of 24 squaring rounds (a multiply on
// the shared 32x32 multiplier and a log step each), and 8 single steps;
// a silent frame ends after 2 more steps.
// Reset (rst_n low, synchronous) clears the step, the sum, the count and the output valid flag.
// A result waits in the output register under out_stall while new samples
// are taken; the next frame-end result waits at its last step until it frees.
module rms_sound_level_db_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [rmsdb_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic                                     in_last,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [rmsdb_pkg::LEVEL_W-1:0]     out_level_db
);

  rmsdb_pkg::uword_t uw;
  rmsdb_pkg::pc_t    pc_r, pc_nxt;

  logic [rmsdb_pkg::SAMPLE_W:0]   samp_abs_r;
  logic                           last_r;
  logic [rmsdb_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic [rmsdb_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [rmsdb_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [rmsdb_pkg::SUM_W-1:0]    norm_r, norm_nxt;
  logic [rmsdb_pkg::EXP_W-1:0]    exp_r, exp_nxt;
  logic [rmsdb_pkg::MANT_W-1:0]   mant_r, mant_nxt;
  logic [rmsdb_pkg::FRAC_W-1:0]   frac_r, frac_nxt;
  logic [rmsdb_pkg::RND_W-1:0]    rnd_r, rnd_nxt;
  logic [rmsdb_pkg::LOG_W-1:0]    log_sum_r, log_sum_nxt;
  logic [rmsdb_pkg::DIFF_W-1:0]   diff_r, diff_nxt;
  logic [rmsdb_pkg::DIFF_W-1:0]   dmag_r, dmag_nxt;
  logic                           dneg_r, dneg_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [rmsdb_pkg::LEVEL_W-1:0]  out_level_r, out_level_nxt;

  logic                           in_fire;
  logic                           out_free;
  logic                           emit_fire;
  logic signed [rmsdb_pkg::SAMPLE_W:0] samp_ext;
  logic [rmsdb_pkg::SAMPLE_W:0]   samp_abs;
  logic [rmsdb_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [rmsdb_pkg::MANT_W:0]     sq_top;
  logic [rmsdb_pkg::PROD_W-1:0]   prod_rnd;
  logic [rmsdb_pkg::MAG_W-1:0]    mag;
  logic [rmsdb_pkg::LEVEL_W-1:0]  level;

  assign uw        = rmsdb_pkg::ucode(pc_r);
  assign in_stall  = (uw.op != rmsdb_pkg::U_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = ((uw.op == rmsdb_pkg::U_EMIT) || (uw.op == rmsdb_pkg::U_FLOOR))
                     && out_free;

  assign out_valid    = out_valid_r;
  assign out_level_db = out_level_r;

  // The magnitude is taken at the input so the square needs no sign handling.
  assign samp_ext = {in_sample[rmsdb_pkg::SAMPLE_W-1], in_sample};
  assign samp_abs = samp_ext[rmsdb_pkg::SAMPLE_W] ? (-samp_ext) : samp_ext;

  always_comb begin
    unique case (uw.op)
      rmsdb_pkg::U_SQUARE: begin
        mul_a = rmsdb_pkg::MUL_W'(samp_abs_r);
        mul_b = rmsdb_pkg::MUL_W'(samp_abs_r);
      end
      rmsdb_pkg::U_MUL_M: begin
        mul_a = rmsdb_pkg::MUL_W'(mant_r);
        mul_b = rmsdb_pkg::MUL_W'(mant_r);
      end
      rmsdb_pkg::U_MUL_D: begin
        mul_a = rmsdb_pkg::MUL_W'(dmag_r);
        mul_b = rmsdb_pkg::MUL_W'(rmsdb_pkg::DB_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Square of the Q30 mantissa brought back to Q30; its top bit means >= 2.
  assign sq_top = prod_r[(rmsdb_pkg::MANT_W-1) +: (rmsdb_pkg::MANT_W+1)];

  // Round the Q40 magnitude to nearest, halves away from zero, then saturate.
  assign prod_rnd = prod_r + (rmsdb_pkg::PROD_W'(1) << (rmsdb_pkg::ROUND_SHIFT - 1));
  assign mag      = prod_rnd[rmsdb_pkg::PROD_W-1:rmsdb_pkg::ROUND_SHIFT];

  always_comb begin
    if (dneg_r) begin
      if (mag > rmsdb_pkg::MAG_W'(32768)) begin
        level = rmsdb_pkg::LEVEL_W'(16'h8000);
      end else begin
        level = rmsdb_pkg::LEVEL_W'(-mag);
      end
    end else begin
      if (mag > rmsdb_pkg::MAG_W'(32767)) begin
        level = rmsdb_pkg::LEVEL_W'(16'h7fff);
      end else begin
        level = mag[rmsdb_pkg::LEVEL_W-1:0];
      end
    end
  end

  // Datapath: the micro-operation of the current step.
  always_comb begin
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    norm_nxt      = norm_r;
    exp_nxt       = exp_r;
    mant_nxt      = mant_r;
    frac_nxt      = frac_r;
    rnd_nxt       = rnd_r;
    log_sum_nxt   = log_sum_r;
    diff_nxt      = diff_r;
    dmag_nxt      = dmag_r;
    dneg_nxt      = dneg_r;
    out_level_nxt = out_level_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    unique case (uw.op) inside
      rmsdb_pkg::U_IDLE: begin
      end
      rmsdb_pkg::U_SQUARE, rmsdb_pkg::U_MUL_M, rmsdb_pkg::U_MUL_D: begin
        prod_nxt = mul_a * mul_b;
      end
      rmsdb_pkg::U_ACC: begin
        // Samples past the frame limit are dropped, the marked one included.
        if (count_r < rmsdb_pkg::CNT_W'(rmsdb_pkg::MAX_SAMPLES)) begin
          sum_nxt   = sum_r + rmsdb_pkg::SUM_W'(prod_r[rmsdb_pkg::MUL_W-1:0]);
          count_nxt = count_r + rmsdb_pkg::CNT_W'(1);
        end
      end
      rmsdb_pkg::U_LOAD_SUM: begin
        norm_nxt = sum_r;
        exp_nxt  = rmsdb_pkg::EXP_W'(rmsdb_pkg::SUM_W - 1);
      end
      rmsdb_pkg::U_NORM: begin
        if (!norm_r[rmsdb_pkg::SUM_W-1]) begin
          norm_nxt = norm_r << 1;
          exp_nxt  = exp_r - rmsdb_pkg::EXP_W'(1);
        end
      end
      rmsdb_pkg::U_LOG_INIT: begin
        mant_nxt = norm_r[rmsdb_pkg::SUM_W-1 -: rmsdb_pkg::MANT_W];
        frac_nxt = '0;
        rnd_nxt  = '0;
      end
      rmsdb_pkg::U_LOG_STEP: begin
        if (sq_top[rmsdb_pkg::MANT_W]) begin
          mant_nxt = sq_top[rmsdb_pkg::MANT_W:1];
          frac_nxt = {frac_r[rmsdb_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          mant_nxt = sq_top[rmsdb_pkg::MANT_W-1:0];
          frac_nxt = {frac_r[rmsdb_pkg::FRAC_W-2:0], 1'b0};
        end
        rnd_nxt = rnd_r + rmsdb_pkg::RND_W'(1);
      end
      rmsdb_pkg::U_SAVE_LOAD_CNT: begin
        log_sum_nxt = {exp_r, frac_r};
        norm_nxt    = rmsdb_pkg::SUM_W'(count_r);
        exp_nxt     = rmsdb_pkg::EXP_W'(rmsdb_pkg::SUM_W - 1);
      end
      rmsdb_pkg::U_DIFF: begin
        diff_nxt = rmsdb_pkg::DIFF_W'(log_sum_r) - rmsdb_pkg::DIFF_W'({exp_r, frac_r})
                   - rmsdb_pkg::DIFF_OFFSET;
      end
      rmsdb_pkg::U_ABS: begin
        dneg_nxt = diff_r[rmsdb_pkg::DIFF_W-1];
        dmag_nxt = diff_r[rmsdb_pkg::DIFF_W-1] ? (-diff_r) : diff_r;
      end
      rmsdb_pkg::U_EMIT, rmsdb_pkg::U_FLOOR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = (uw.op == rmsdb_pkg::U_FLOOR) ?
                          rmsdb_pkg::LEVEL_W'(16'h8000) : level;
          sum_nxt       = '0;
          count_nxt     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: next step from the jump condition of the control word.
  always_comb begin
    unique case (uw.cond)
      rmsdb_pkg::C_NEXT:     pc_nxt = pc_r + rmsdb_pkg::PC_W'(1);
      rmsdb_pkg::C_WAIT_IN:  pc_nxt = in_fire ? pc_r + rmsdb_pkg::PC_W'(1) : pc_r;
      rmsdb_pkg::C_NOT_LAST: pc_nxt = last_r ? pc_r + rmsdb_pkg::PC_W'(1) : uw.target;
      rmsdb_pkg::C_SUM_ZERO: pc_nxt = (sum_r == '0) ? uw.target
                                                    : pc_r + rmsdb_pkg::PC_W'(1);
      rmsdb_pkg::C_NORM:     pc_nxt = norm_r[rmsdb_pkg::SUM_W-1] ?
                                      pc_r + rmsdb_pkg::PC_W'(1) : uw.target;
      rmsdb_pkg::C_ROUNDS:   pc_nxt = (rnd_r == rmsdb_pkg::RND_W'(rmsdb_pkg::FRAC_W - 1)) ?
                                      pc_r + rmsdb_pkg::PC_W'(1) : uw.target;
      rmsdb_pkg::C_OUT_FREE: pc_nxt = out_free ? uw.target : pc_r;
      rmsdb_pkg::C_JUMP:     pc_nxt = uw.target;
      default:               pc_nxt = rmsdb_pkg::S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= rmsdb_pkg::S_WAIT;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      samp_abs_r <= samp_abs;
      last_r     <= in_last;
    end
    prod_r      <= prod_nxt;
    norm_r      <= norm_nxt;
    exp_r       <= exp_nxt;
    mant_r      <= mant_nxt;
    frac_r      <= frac_nxt;
    rnd_r       <= rnd_nxt;
    log_sum_r   <= log_sum_nxt;
    diff_r      <= diff_nxt;
    dmag_r      <= dmag_nxt;
    dneg_r      <= dneg_nxt;
    out_level_r <= out_level_nxt;
  end

  // The count never runs past the frame limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rmsdb_pkg::CNT_W'(rmsdb_pkg::MAX_SAMPLES))
    else $error("sample count above frame limit");

  // The log mantissa stays normalized in [1,2) through every squaring round.
  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == rmsdb_pkg::U_LOG_INIT || uw.op == rmsdb_pkg::U_LOG_STEP)
    |=> mant_r[rmsdb_pkg::MANT_W-1])
    else $error("log mantissa lost its leading one");

  // A new result beat appears only from an emit step.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(emit_fire))
    else $error("output valid without an emit step");

  // Emitting a level starts the next frame from an empty accumulator.
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (sum_r == '0) && (count_r == '0))
    else $error("accumulator not cleared after a frame");

endmodule

### tb/sv/rms_level_checker.sv
// Checker for the RMS sound level core: watches the sample and level channels,
// predicts each frame's level in 1/256 dB and compares it with the level beats.
// Depends on rmsdb_pkg for the frame length limit and the port widths.
module rms_level_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [rmsdb_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                  in_last,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [rmsdb_pkg::LEVEL_W-1:0]  out_level_db,
  output int                                    errors,
  output int                                    levels_pending,
  output int                                    levels_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_MAX  = rmsdb_pkg::MAX_SAMPLES;
  localparam int unsigned LOG_FRAC   = 24;
  localparam int unsigned NORM_POINT = 30;
  // 2560*log10(2) in Q16: one log2 unit expressed in 1/256 dB.
  localparam longint DB_PER_LOG2 = 64'sd50504453;

  logic [63:0] energy_acc;
  int unsigned frame_len;
  logic signed [rmsdb_pkg::LEVEL_W-1:0] level_q[$];
  int mismatches;
  int matched;

  // Base-2 logarithm in unsigned Q.24 by repeated squaring of the mantissa.
  function automatic logic [63:0] log2_fixed(input logic [63:0] x);
    int unsigned msb;
    logic [63:0] mant;
    logic [63:0] frac;
    int i;
    msb = 0;
    for (i = 0; i < 64; i++) begin
      if (x[i]) msb = i;
    end
    if (msb >= NORM_POINT) mant = x >> (msb - NORM_POINT);
    else mant = x << (NORM_POINT - msb);
    frac = '0;
    for (i = 1; i <= LOG_FRAC; i++) begin
      mant = (mant * mant) >> NORM_POINT;
      if (mant >= (64'd2 << NORM_POINT)) begin
        mant = mant >> 1;
        frac[LOG_FRAC - i] = 1'b1;
      end
    end
    return (64'(msb) << LOG_FRAC) | frac;
  endfunction

  // Level of a frame: 3.0103 dB * (log2(energy) - log2(n) - 20), rounded with
  // halves away from zero; silence maps to the floor.
  function automatic logic signed [15:0] frame_level(input logic [63:0] energy,
                                                     input int unsigned n);
    longint diff;
    longint prod;
    longint r;
    logic [63:0] mag;
    if (energy == 0 || n == 0) return 16'sh8000;
    diff = longint'(log2_fixed(energy)) - longint'(log2_fixed(64'(n)))
           - (longint'(20) << LOG_FRAC);
    prod = diff * DB_PER_LOG2;
    mag = (prod < 0) ? 64'(-prod) : 64'(prod);
    mag = (mag + (64'd1 << 39)) >> 40;
    if (mag > 64'd40000) mag = 64'd40000;
    r = (prod < 0) ? -longint'(mag) : longint'(mag);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  always @(posedge clk) begin
    logic signed [15:0] want;
    longint sq;
    if (!rst_n) begin
      energy_acc = '0;
      frame_len  = 0;
      level_q.delete();
      mismatches = 0;
      matched    = 0;
    end else begin
      // Sample beats first, so a level can never be looked for before its frame.
      if (in_valid && !in_stall) begin
        // Samples past the frame limit are dropped, but a marked one still ends it.
        if (frame_len < FRAME_MAX) begin
          sq = longint'(in_sample) * longint'(in_sample);
          energy_acc = energy_acc + 64'(sq);
          frame_len++;
        end
        if (in_last) begin
          level_q.push_back(frame_level(energy_acc, frame_len));
          energy_acc = '0;
          frame_len  = 0;
        end
      end
      if (out_valid && !out_stall) begin
        if (level_q.size() == 0) begin
          $error("level_db beat with no level pending: actual %0d", out_level_db);
          mismatches++;
        end else begin
          want = level_q.pop_front();
          if (out_level_db !== want) begin
            $error("level_db mismatch: expected %0d, actual %0d", want, out_level_db);
            mismatches++;
          end
          matched++;
        end
      end
    end
    errors         <= mismatches;
    levels_pending <= level_q.size();
    levels_checked <= matched;
  end

endmodule

### tb/sv/tb_rms_sound_level_db_core.sv
// Testbench top for the RMS sound level core: clock, reset, sample stimulus,
// level-channel stalls and the verdict. Depends on rmsdb_pkg, the core and
// rms_level_checker, which does all prediction and comparison.
module tb_rms_sound_level_db_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 250;

  typedef enum int {AMP_FULL, AMP_QUIET, AMP_SILENT, AMP_RAIL} amp_style_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [rmsdb_pkg::SAMPLE_W-1:0] in_sample;
  logic in_last;
  logic out_valid;
  logic out_stall;
  logic signed [rmsdb_pkg::LEVEL_W-1:0] out_level_db;

  int errors;
  int levels_pending;
  int levels_checked;
  int samples_sent;
  int tx_idle_pct;
  int rx_idle_pct;
  int holds_asked;
  int cycles;

  rms_sound_level_db_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_level_db (out_level_db)
  );

  rms_level_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_level_db   (out_level_db),
    .errors         (errors),
    .levels_pending (levels_pending),
    .levels_checked (levels_checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Level receiver: random stalls, plus a long hold-off whenever one is asked.
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_seen) begin
        holds_seen = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  function automatic logic signed [15:0] pick_sample(input amp_style_t style);
    logic signed [15:0] s;
    case (style)
      AMP_QUIET: begin
        s = 16'($urandom_range(30));
        s = s - 16'sd15;
      end
      AMP_SILENT: s = '0;
      AMP_RAIL:   s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default:    s = 16'($urandom());
    endcase
    return s;
  endfunction

  // Offer one sample beat and return at the edge that accepts it.
  task automatic put_sample(input logic signed [15:0] s, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid  <= 1'b0;
      in_sample <= 16'($urandom());
      in_last   <= 1'($urandom());
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_last   <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic send_frame(input int len, input amp_style_t style);
    int i;
    for (i = 0; i < len; i++) put_sample(pick_sample(style), i == len - 1);
  endtask

  task automatic random_frames(input int budget);
    int stop_at;
    int len;
    amp_style_t style;
    stop_at = samples_sent + budget;
    while (samples_sent < stop_at) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      case ($urandom_range(9)) inside
        0:       style = AMP_SILENT;
        1:       style = AMP_RAIL;
        2, 3:    style = AMP_QUIET;
        default: style = AMP_FULL;
      endcase
      send_frame(len, style);
    end
  endtask

  // Stop offering samples until every predicted level has come out.
  task automatic wait_levels_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (levels_pending != 0) @(posedge clk);
  endtask

  initial begin
    int k;
    cycles       = 0;
    samples_sent = 0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    holds_asked  = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    in_last      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-sample frames at the edges of the sample range, silent frames,
    // and frames whose closing sample is zero.
    put_sample(16'sd0, 1'b1);
    put_sample(16'sh8000, 1'b1);
    put_sample(16'sh7fff, 1'b1);
    put_sample(16'sd1, 1'b1);
    put_sample(-16'sd1, 1'b1);
    put_sample(16'sd0, 1'b0);
    put_sample(16'sd0, 1'b0);
    put_sample(16'sd0, 1'b1);
    put_sample(16'sd0, 1'b0);
    put_sample(16'sd0, 1'b0);
    put_sample(-16'sd2, 1'b1);
    put_sample(16'sd12345, 1'b0);
    put_sample(-16'sd12345, 1'b0);
    put_sample(16'sh7fff, 1'b0);
    put_sample(16'sh8000, 1'b1);
    put_sample(16'sh8000, 1'b0);
    put_sample(16'sd0, 1'b1);
    wait_levels_drained();

    tx_idle_pct = 26;
    rx_idle_pct <= 75;
    random_frames(200);
    wait_levels_drained();

    tx_idle_pct = 75;
    rx_idle_pct <= 26;
    random_frames(200);
    wait_levels_drained();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    // Hold the level channel while short frames keep coming, so results back
    // up inside the core and it has to stall the sample channel.
    holds_asked <= holds_asked + 1;
    for (k = 0; k < 8; k++) send_frame(2, AMP_FULL);
    wait_levels_drained();

    // A frame right at the length limit, then one that runs past it so the
    // marked closing sample itself is dropped from the sums.
    send_frame(rmsdb_pkg::MAX_SAMPLES, AMP_RAIL);
    send_frame(rmsdb_pkg::MAX_SAMPLES + 2, AMP_FULL);
    random_frames(20);

    wait_levels_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples; %0d frame levels checked, from silent, quiet, rail and",
             samples_sent, levels_checked);
    $display("full-range frames, frames at and past the length limit, and a long output hold.");
    if (errors == 0 && levels_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
